@@ src/cmdu_pkg.sv @@
// types, constants and helpers shared by the multiply/divide unit
`default_nettype none
package cmdu_pkg;

    localparam int NUM_CELLS = 32;
    localparam int BYTE_W    = 8;
    localparam int PAIR_W    = 16;
    localparam int WIDE_W    = 32;

    typedef enum logic [2:0] {
        OP_MUL_HL    = 3'd0,
        OP_MULS_HL   = 3'd1,
        OP_MUL_DEHL  = 3'd2,
        OP_MULS_DEHL = 3'd3,
        OP_DIV_HL    = 3'd4,
        OP_DIVS_HL   = 3'd5,
        OP_DIV_DEHL  = 3'd6,
        OP_DIVS_DEHL = 3'd7
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [PAIR_W-1:0] hl;
        logic [PAIR_W-1:0] de;
        logic              dz;
        logic              neg_q;
        logic              neg_r;
    } t_meta;

    typedef struct packed {
        logic              is_div;
        logic [PAIR_W-1:0] d;
        logic [PAIR_W:0]   r;
        logic [WIDE_W-1:0] x;
        t_meta             meta;
    } t_stage;

    function automatic logic [BYTE_W-1:0] abs8(input logic [BYTE_W-1:0] v, input logic sg);
        abs8 = (sg && v[BYTE_W-1]) ? -v : v;
    endfunction

    function automatic logic [PAIR_W-1:0] abs16(input logic [PAIR_W-1:0] v, input logic sg);
        abs16 = (sg && v[PAIR_W-1]) ? -v : v;
    endfunction

    function automatic logic [WIDE_W-1:0] abs32(input logic [WIDE_W-1:0] v, input logic sg);
        abs32 = (sg && v[WIDE_W-1]) ? -v : v;
    endfunction

endpackage
`default_nettype wire

@@ src/cmdu_if.sv @@
// item channels of the multiply/divide unit
`default_nettype none
interface cmdu_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  opcode;
    logic [15:0] reg_hl;
    logic [15:0] reg_de;
    logic [15:0] reg_bc;
    logic [7:0]  reg_a;
    modport source (output valid, opcode, reg_hl, reg_de, reg_bc, reg_a, input ready);
    modport sink   (input valid, opcode, reg_hl, reg_de, reg_bc, reg_a, output ready);
endinterface

interface cmdu_rsp_if;
    logic        valid;
    logic        ready;
    logic [15:0] new_hl;
    logic [15:0] new_de;
    logic        divide_by_zero;
    modport source (output valid, new_hl, new_de, divide_by_zero, input ready);
    modport sink   (input valid, new_hl, new_de, divide_by_zero, output ready);
endinterface
`default_nettype wire

@@ src/cmdu_cell.sv @@
// one shift-add / restoring-subtract step of the multiply/divide chain
`default_nettype none
module cmdu_cell
    import cmdu_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_en,
    input  wire logic   i_valid,
    input  wire t_stage i_stage,
    output logic        o_valid,
    output t_stage      o_stage
);
    logic   r_valid;
    t_stage r_stage;
    t_stage n_stage;
    logic [PAIR_W:0] trial;
    logic [PAIR_W:0] s_add;
    logic            ge;

    always_comb begin
        n_stage = i_stage;
        trial   = {i_stage.r[PAIR_W-1:0], i_stage.x[WIDE_W-1]};
        ge      = (trial >= {1'b0, i_stage.d});
        s_add   = {1'b0, i_stage.r[PAIR_W-1:0]}
                + (i_stage.x[0] ? {1'b0, i_stage.d} : '0);
        if (i_stage.is_div) begin
            n_stage.r = ge ? (trial - {1'b0, i_stage.d}) : trial;
            n_stage.x = {i_stage.x[WIDE_W-2:0], ge};
        end else begin
            n_stage.r = {1'b0, s_add[PAIR_W:1]};
            n_stage.x = {s_add[0], i_stage.x[WIDE_W-1:1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_stage <= n_stage;
        end
    end

    assign o_valid = r_valid;
    assign o_stage = r_stage;
endmodule
`default_nettype wire

@@ src/cpu_multiply_divide_unit.sv @@
// multiply/divide unit: operand preparation, chain of step cells, sign fix and result register
// Takes one item per cycle while the result side does not stall. An input register holds the
// operand magnitudes, 32 cells each perform one multiply or divide step, and a result register
// holds the sign-corrected, selected result. The whole pipe advances whenever the result
// register is empty or being taken, so a stall on the result side holds every stage.
`default_nettype none
module cpu_multiply_divide_unit
    import cmdu_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    cmdu_req_if.sink  i_req,
    cmdu_rsp_if.source o_rsp
);
    logic   en;
    logic   r_pre_valid;
    t_stage r_pre;
    t_stage n_pre;
    logic   cell_valid [NUM_CELLS+1];
    t_stage cell_stage [NUM_CELLS+1];

    logic        r_out_valid;
    logic [15:0] r_new_hl;
    logic [15:0] r_new_de;
    logic        r_dz;
    logic [15:0] n_new_hl;
    logic [15:0] n_new_de;

    logic              sg;
    logic [BYTE_W-1:0] hb;
    logic [BYTE_W-1:0] lb;
    logic [WIDE_W-1:0] dehl;
    t_stage            last;
    logic [WIDE_W-1:0] q;
    logic [PAIR_W-1:0] rm;

    assign en          = !r_out_valid || o_rsp.ready;
    assign i_req.ready = en;

    always_comb begin
        sg   = i_req.opcode[0];
        hb   = i_req.reg_hl[15:8];
        lb   = i_req.reg_hl[7:0];
        dehl = {i_req.reg_de, i_req.reg_hl};
        n_pre = '0;
        n_pre.meta.op = t_op'(i_req.opcode);
        n_pre.meta.hl = i_req.reg_hl;
        n_pre.meta.de = i_req.reg_de;
        case (t_op'(i_req.opcode))
            OP_MUL_HL, OP_MULS_HL: begin
                n_pre.d          = {8'd0, abs8(hb, sg)};
                n_pre.x          = {24'd0, abs8(lb, sg)};
                n_pre.meta.neg_q = sg && (hb[7] ^ lb[7]);
            end
            OP_MUL_DEHL, OP_MULS_DEHL: begin
                n_pre.d          = abs16(i_req.reg_de, sg);
                n_pre.x          = {16'd0, abs16(i_req.reg_hl, sg)};
                n_pre.meta.neg_q = sg && (i_req.reg_de[15] ^ i_req.reg_hl[15]);
            end
            OP_DIV_HL, OP_DIVS_HL: begin
                n_pre.is_div     = 1'b1;
                n_pre.d          = {8'd0, abs8(i_req.reg_a, sg)};
                n_pre.x          = {16'd0, abs16(i_req.reg_hl, sg)};
                n_pre.meta.neg_q = sg && (i_req.reg_hl[15] ^ i_req.reg_a[7]);
                n_pre.meta.neg_r = sg && i_req.reg_hl[15];
                n_pre.meta.dz    = (i_req.reg_a == 8'd0);
            end
            default: begin
                n_pre.is_div     = 1'b1;
                n_pre.d          = abs16(i_req.reg_bc, sg);
                n_pre.x          = abs32(dehl, sg);
                n_pre.meta.neg_q = sg && (i_req.reg_de[15] ^ i_req.reg_bc[15]);
                n_pre.meta.neg_r = sg && i_req.reg_de[15];
                n_pre.meta.dz    = (i_req.reg_bc == 16'd0);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pre_valid <= 1'b0;
        end else if (en) begin
            r_pre_valid <= i_req.valid;
        end
        if (en) begin
            r_pre <= n_pre;
        end
    end

    assign cell_valid[0] = r_pre_valid;
    assign cell_stage[0] = r_pre;

    for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
        cmdu_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (cell_valid[g]),
            .i_stage (cell_stage[g]),
            .o_valid (cell_valid[g+1]),
            .o_stage (cell_stage[g+1])
        );
    end

    always_comb begin
        last     = cell_stage[NUM_CELLS];
        q        = last.meta.neg_q ? -last.x : last.x;
        rm       = last.meta.neg_r ? -last.r[PAIR_W-1:0] : last.r[PAIR_W-1:0];
        n_new_hl = last.meta.hl;
        n_new_de = last.meta.de;
        case (last.meta.op)
            OP_MUL_HL, OP_MULS_HL: begin
                n_new_hl = q[15:0];
            end
            OP_MUL_DEHL, OP_MULS_DEHL: begin
                n_new_hl = q[15:0];
                n_new_de = q[31:16];
            end
            OP_DIV_HL, OP_DIVS_HL: begin
                if (!last.meta.dz) begin
                    n_new_hl = {rm[7:0], q[7:0]};
                end
            end
            default: begin
                if (!last.meta.dz) begin
                    n_new_hl = q[15:0];
                    n_new_de = rm;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= cell_valid[NUM_CELLS];
        end
        if (en) begin
            r_new_hl <= n_new_hl;
            r_new_de <= n_new_de;
            r_dz     <= last.meta.dz;
        end
    end

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.new_hl         = r_new_hl;
    assign o_rsp.new_de         = r_new_de;
    assign o_rsp.divide_by_zero = r_dz;
endmodule
`default_nettype wire

@@ src/cmdu_checker.sv @@
// port-level checks of the multiply/divide unit
`default_nettype none
module cmdu_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_ready,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [15:0] i_new_hl,
    input wire logic [15:0] i_new_de,
    input wire logic        i_dz
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result item dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_new_hl) && $stable(i_new_de) && $stable(i_dz))
        else $error("stalled result item changed");

    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input blocked with empty result register");

    a_stall_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |-> !i_in_ready)
        else $error("item taken while the pipe is stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid straight after reset");
endmodule

bind cpu_multiply_divide_unit cmdu_checker u_cmdu_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_new_hl    (o_rsp.new_hl),
    .i_new_de    (o_rsp.new_de),
    .i_dz        (o_rsp.divide_by_zero)
);
`default_nettype wire

@@ tb/cmdu_tb_scoreboard.sv @@
// scoreboard of the multiply/divide unit testbench: predicts and checks each result
`timescale 1ns / 1ps
class cmdu_result_board;
    logic [15:0] exp_hl[$];
    logic [15:0] exp_de[$];
    logic        exp_dz[$];
    int          n_errors;

    function new();
        n_errors = 0;
    endfunction

    function void note_item(cmdu_pkg::t_op op, logic [15:0] hl, logic [15:0] de,
                            logic [15:0] bc, logic [7:0] a);
        logic [15:0] nhl;
        logic [15:0] nde;
        logic        dz;
        logic [31:0] dehl;
        logic [31:0] p;
        logic signed [31:0] sn;
        logic signed [31:0] sd;
        logic signed [31:0] sq;
        logic signed [31:0] sr;
        logic [31:0] uq;
        logic [31:0] ur;
        nhl  = hl;
        nde  = de;
        dz   = 1'b0;
        dehl = {de, hl};
        case (op)
            cmdu_pkg::OP_MUL_HL: begin
                p   = hl[15:8] * hl[7:0];
                nhl = p[15:0];
            end
            cmdu_pkg::OP_MULS_HL: begin
                sn  = $signed(hl[15:8]) * $signed(hl[7:0]);
                nhl = sn[15:0];
            end
            cmdu_pkg::OP_MUL_DEHL: begin
                p   = de * hl;
                nhl = p[15:0];
                nde = p[31:16];
            end
            cmdu_pkg::OP_MULS_DEHL: begin
                sn  = $signed(de) * $signed(hl);
                nhl = sn[15:0];
                nde = sn[31:16];
            end
            cmdu_pkg::OP_DIV_HL: begin
                if (a == 8'd0) begin
                    dz = 1'b1;
                end else begin
                    uq  = hl / a;
                    ur  = hl % a;
                    nhl = {ur[7:0], uq[7:0]};
                end
            end
            cmdu_pkg::OP_DIVS_HL: begin
                if (a == 8'd0) begin
                    dz = 1'b1;
                end else begin
                    sn  = $signed(hl);
                    sd  = $signed(a);
                    sq  = sn / sd;
                    sr  = sn % sd;
                    nhl = {sr[7:0], sq[7:0]};
                end
            end
            cmdu_pkg::OP_DIV_DEHL: begin
                if (bc == 16'd0) begin
                    dz = 1'b1;
                end else begin
                    uq  = dehl / bc;
                    ur  = dehl % bc;
                    nhl = uq[15:0];
                    nde = ur[15:0];
                end
            end
            default: begin
                if (bc == 16'd0) begin
                    dz = 1'b1;
                end else begin
                    longint ln;
                    longint ld;
                    ln  = longint'($signed(dehl));
                    ld  = longint'($signed(bc));
                    nhl = 16'(ln / ld);
                    nde = 16'(ln % ld);
                end
            end
        endcase
        exp_hl.push_back(nhl);
        exp_de.push_back(nde);
        exp_dz.push_back(dz);
    endfunction

    function void check_result(logic [15:0] hl, logic [15:0] de, logic dz);
        if (exp_hl.size() == 0) begin
            n_errors++;
            if (n_errors <= 10)
                $display("unexpected result hl=%h de=%h dz=%b", hl, de, dz);
            return;
        end
        if (hl !== exp_hl[0] || de !== exp_de[0] || dz !== exp_dz[0]) begin
            n_errors++;
            if (n_errors <= 10)
                $display("mismatch: expected hl=%h de=%h dz=%b, got hl=%h de=%h dz=%b",
                         exp_hl[0], exp_de[0], exp_dz[0], hl, de, dz);
        end
        void'(exp_hl.pop_front());
        void'(exp_de.pop_front());
        void'(exp_dz.pop_front());
    endfunction

    function int pending();
        return exp_hl.size();
    endfunction
endclass

@@ tb/testbench.sv @@
// top of the multiply/divide unit testbench: clock, reset, stimulus and result checking
`timescale 1ns / 1ps
module testbench;
    import cmdu_pkg::*;

    logic i_clk;
    logic i_rst_n;
    bit   idle_on;

    cmdu_req_if req_if ();
    cmdu_rsp_if rsp_if ();

    cpu_multiply_divide_unit dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if.sink),
        .o_rsp  (rsp_if.source)
    );

    cmdu_result_board board = new();

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    task automatic send_item(t_op op, logic [15:0] hl, logic [15:0] de,
                             logic [15:0] bc, logic [7:0] a);
        int gap;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 15);
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid  <= 1'b1;
        req_if.opcode <= op;
        req_if.reg_hl <= hl;
        req_if.reg_de <= de;
        req_if.reg_bc <= bc;
        req_if.reg_a  <= a;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        board.note_item(op, hl, de, bc, a);
    endtask

    task automatic send_random(bit zero_div);
        t_op         op;
        logic [15:0] hl;
        logic [15:0] de;
        logic [15:0] bc;
        logic [7:0]  a;
        op = t_op'(3'($urandom_range(0, 7)));
        hl = 16'($urandom());
        de = 16'($urandom());
        bc = 16'($urandom());
        a  = 8'($urandom());
        case ($urandom_range(0, 7))
            0: bc = 16'($urandom_range(1, 3));
            1: a  = 8'($urandom_range(1, 3));
            2: de = 16'($urandom_range(0, 2));
            3: hl = {($urandom_range(0, 1) != 0) ? 8'hff : 8'h00, 8'($urandom())};
            default: ;
        endcase
        if (zero_div) begin
            a  = 8'd0;
            bc = 16'd0;
        end
        send_item(op, hl, de, bc, a);
    endtask

    // result side: check every accepted result item
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready)
            board.check_result(rsp_if.new_hl, rsp_if.new_de, rsp_if.divide_by_zero);
    end

    // result side: random stall bursts, none in the last part
    initial begin
        int stall;
        rsp_if.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            rsp_if.ready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge i_clk);
            if (idle_on) begin
                stall = $urandom_range(1, 15);
                rsp_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
        end
    end

    initial begin
        t_op op;
        req_if.valid  = 1'b0;
        req_if.opcode = '0;
        req_if.reg_hl = '0;
        req_if.reg_de = '0;
        req_if.reg_bc = '0;
        req_if.reg_a  = '0;
        i_rst_n       = 1'b0;
        idle_on       = 1'b1;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // directed: every operation at the field extremes, zero divisors, overflowing quotients
        for (int k = 0; k < 8; k++) begin
            op = t_op'(3'(k));
            send_item(op, 16'hffff, 16'hffff, 16'hffff, 8'hff);
            send_item(op, 16'h8000, 16'h8000, 16'h0001, 8'h01);
        end
        send_item(OP_DIV_HL, 16'h1234, 16'h5678, 16'h0000, 8'h00);
        send_item(OP_DIVS_HL, 16'h8000, 16'h5678, 16'h0000, 8'h00);
        send_item(OP_DIV_DEHL, 16'h1234, 16'h5678, 16'h0000, 8'h00);
        send_item(OP_DIVS_DEHL, 16'h0000, 16'h8000, 16'h0000, 8'h80);
        send_item(OP_DIVS_HL, 16'h8000, 16'h0000, 16'h0000, 8'hff);
        send_item(OP_DIVS_DEHL, 16'h0000, 16'h8000, 16'hffff, 8'h01);
        send_item(OP_MULS_HL, 16'h8080, 16'h0000, 16'h0000, 8'h00);
        send_item(OP_DIVS_HL, 16'hfff9, 16'h0000, 16'h0000, 8'h02);
        send_item(OP_MUL_HL, 16'h0000, 16'h0000, 16'h0000, 8'h00);
        for (int n = 0; n < 180; n++) send_random($urandom_range(0, 15) == 0);
        // hold off until the pipe has drained
        req_if.valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        for (int n = 0; n < 120; n++) send_random($urandom_range(0, 15) == 0);
        idle_on = 1'b0;
        for (int n = 0; n < 100; n++) send_random(1'b0);
        req_if.valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (board.n_errors == 0 && board.pending() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("Regression FAIL");
        $finish;
    end
endmodule

@@ files.f @@
src/cmdu_pkg.sv
src/cmdu_if.sv
src/cmdu_cell.sv
src/cpu_multiply_divide_unit.sv
src/cmdu_checker.sv
tb/cmdu_tb_scoreboard.sv
tb/testbench.sv
